// File: rtl/mvna_pkg.sv
`default_nettype none

package mvna_pkg;

	// Fixed field widths
	localparam int IDX_IN_W = 10;
	localparam int POS_W    = 16;
	localparam int NORM_W   = 34;
	localparam int SUM_W    = 43;
	localparam int TOTAL_W  = 8;
	localparam int STAT_W   = 2;
	localparam int REQ_W    = 2;

	// Divider step counter covers SUM_W quotient bits
	localparam int DIVC_W = $clog2(SUM_W + 1);

	// Default sizing
	localparam int DEF_VERTEX_DEPTH = 1024;
	localparam int DEF_MAX_FACES    = 255;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FACE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FACES = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

endpackage

`default_nettype wire

// File: rtl/mesh_vertex_normal_accumulator_unit.sv
`default_nettype none
// Vertex normal accumulator.
// Command port: a request is taken on a rising edge with start high and busy low.
// req_type selects write vertex, add face or read vertex normal; vertex_a/b/c
// and pos_x/y/z carry the operands. Exactly one result follows each request:
// done is high for one cycle with status, norm_x/y/z and face_total valid.
// The receiver cannot stall; results are never held or retried.
// Indices are first reduced modulo VERTEX_DEPTH in R shift-and-subtract steps
// (R = 0 when VERTEX_DEPTH >= 1024, else floor(log2(1023/VERTEX_DEPTH))+1).
// A write vertex or unknown code then ends in the execute state; add face fetches
// the three corners, multiplies, forms the normal and writes back three corners,
// or ends before the write-back when rejected as full; a faceless read skips the divider.
// A new request is accepted in the done cycle. Face requests are bounded by the
// single read port and single write port of each memory (three corner reads,
// three write-backs); reads by the bit-serial divider, one quotient bit per cycle
// for 43 bits. Reset: after arst_n rises, busy stays high while the accumulator
// memory is cleared one entry per cycle; positions are not cleared.
module mesh_vertex_normal_accumulator_unit #(
	parameter int VERTEX_DEPTH         = mvna_pkg::DEF_VERTEX_DEPTH,
	parameter int MAX_FACES_PER_VERTEX = mvna_pkg::DEF_MAX_FACES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [mvna_pkg::REQ_W-1:0]          req_type,
	input  wire logic [mvna_pkg::IDX_IN_W-1:0]       vertex_a,
	input  wire logic [mvna_pkg::IDX_IN_W-1:0]       vertex_b,
	input  wire logic [mvna_pkg::IDX_IN_W-1:0]       vertex_c,
	input  wire logic signed [mvna_pkg::POS_W-1:0]   pos_x,
	input  wire logic signed [mvna_pkg::POS_W-1:0]   pos_y,
	input  wire logic signed [mvna_pkg::POS_W-1:0]   pos_z,
	output logic                                     done,
	output logic [mvna_pkg::STAT_W-1:0]              status,
	output logic signed [mvna_pkg::NORM_W-1:0]       norm_x,
	output logic signed [mvna_pkg::NORM_W-1:0]       norm_y,
	output logic signed [mvna_pkg::NORM_W-1:0]       norm_z,
	output logic [mvna_pkg::TOTAL_W-1:0]             face_total
);
	import mvna_pkg::*;

	function automatic int red_steps(input int depth);
		int n;
		n = 0;
		while (n < IDX_IN_W && (depth << n) <= ((1 << IDX_IN_W) - 1)) begin
			n++;
		end
		return n;
	endfunction

	localparam int IW        = $clog2(VERTEX_DEPTH);
	localparam int CW        = $clog2(MAX_FACES_PER_VERTEX + 1);
	localparam int ACC_W     = CW + 3 * SUM_W;
	localparam int PW        = 3 * POS_W;
	localparam int RED_STEPS = red_steps(VERTEX_DEPTH);
	localparam int RED_SHIFT = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
	localparam logic [IDX_IN_W-1:0] RED_TOP   = IDX_IN_W'(VERTEX_DEPTH << RED_SHIFT);
	localparam logic [IDX_IN_W-1:0] DEPTH_LOW = IDX_IN_W'(VERTEX_DEPTH);
	localparam logic [IW-1:0]       LAST_IDX  = IW'(VERTEX_DEPTH - 1);
	localparam logic [CW+1:0]       MAX_LIM   = (CW + 2)'(MAX_FACES_PER_VERTEX);
	localparam logic [DIVC_W-1:0]   DIV_LAST  = DIVC_W'(SUM_W - 1);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_REDUCE = 4'd2;
	localparam logic [3:0] ST_EXEC   = 4'd3;
	localparam logic [3:0] ST_FETCH  = 4'd4;
	localparam logic [3:0] ST_MUL    = 4'd5;
	localparam logic [3:0] ST_NORM   = 4'd6;
	localparam logic [3:0] ST_WB     = 4'd7;
	localparam logic [3:0] ST_RDWAIT = 4'd8;
	localparam logic [3:0] ST_DIV    = 4'd9;
	localparam logic [3:0] ST_RDDONE = 4'd10;

	// Memories
	logic [PW-1:0]    pos_mem [VERTEX_DEPTH];
	logic [ACC_W-1:0] acc_mem [VERTEX_DEPTH];
	logic [PW-1:0]    pos_rd_q;
	logic [ACC_W-1:0] acc_rd_q;

	// Control
	logic [3:0]        state_q, state_d;
	logic [IW-1:0]     clr_q;
	logic [1:0]        cnt_q;
	logic [DIVC_W-1:0] dcnt_q;
	logic              done_q;
	logic              emit;

	// Request payload
	logic [REQ_W-1:0]    req_q;
	logic [IDX_IN_W-1:0] raw_q [3];
	logic [IDX_IN_W-1:0] dsh_q;
	logic [PW-1:0]       wpos_q;

	// Face datapath
	logic [PW-1:0]             pos_c_q [3];
	logic [ACC_W-1:0]          acc_c_q [3];
	logic signed [2*POS_W+1:0] prod_q [6];
	logic                      full_q;
	logic signed [NORM_W-1:0]  n_q [3];

	// Divider lanes
	logic [CW-1:0]    divisor_q;
	logic [CW-1:0]    rem_q [3];
	logic [SUM_W-1:0] quo_q [3];
	logic             neg_q [3];

	// Result registers
	logic [STAT_W-1:0]        status_q;
	logic signed [NORM_W-1:0] nrm_q [3];
	logic [TOTAL_W-1:0]       total_q;

	// Combinational helpers
	logic [IW-1:0]            corner [3];
	logic [1:0]               occ [3];
	logic [IW-1:0]            corner_sel;
	logic [1:0]               occ_sel;
	logic [ACC_W-1:0]         acc_sel;
	logic                     pos_we, acc_we;
	logic [IW-1:0]            acc_waddr;
	logic [ACC_W-1:0]         acc_wdata;
	logic signed [POS_W:0]    du [3];
	logic signed [POS_W:0]    dw [3];
	logic signed [2*POS_W+1:0] prod_d [6];
	logic                     full_d;
	logic [CW:0]              rem_sh [3];
	logic                     ge [3];
	logic [STAT_W-1:0]        out_status;
	logic [NORM_W-1:0]        out_n [3];
	logic [TOTAL_W-1:0]       out_total;
	logic [CW-1:0]            rd_count;
	logic [SUM_W-1:0]         qs [3];

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign norm_x     = nrm_q[0];
	assign norm_y     = nrm_q[1];
	assign norm_z     = nrm_q[2];
	assign face_total = total_q;
	assign rd_count   = acc_rd_q[ACC_W-1 -: CW];

	// Corner indices and how often each appears in the face
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			corner[k] = IW'(raw_q[k]);
		end
		for (int k = 0; k < 3; k++) begin
			occ[k] = 2'(corner[k] == corner[0]) + 2'(corner[k] == corner[1])
				+ 2'(corner[k] == corner[2]);
		end
	end

	// Select the corner being fetched or written back
	always_comb begin
		unique case (cnt_q)
			2'd1: begin
				corner_sel = corner[1];
				occ_sel    = occ[1];
				acc_sel    = acc_c_q[1];
			end
			2'd2: begin
				corner_sel = corner[2];
				occ_sel    = occ[2];
				acc_sel    = acc_c_q[2];
			end
			default: begin
				corner_sel = corner[0];
				occ_sel    = occ[0];
				acc_sel    = acc_c_q[0];
			end
		endcase
	end

	// Memory write control; write-back adds the face normal once per slot.
	// A repeated corner always has a zero normal, so only its count needs occ.
	always_comb begin
		pos_we    = (state_q == ST_EXEC) && (req_q == REQ_WRITE);
		acc_we    = 1'b0;
		acc_waddr = corner[0];
		acc_wdata = '0;
		if (state_q == ST_CLEAR) begin
			acc_we    = 1'b1;
			acc_waddr = clr_q;
		end else if (pos_we) begin
			acc_we = 1'b1;
		end else if (state_q == ST_WB) begin
			acc_we    = 1'b1;
			acc_waddr = corner_sel;
			acc_wdata[ACC_W-1 -: CW] = acc_sel[ACC_W-1 -: CW] + CW'(occ_sel);
			for (int k = 0; k < 3; k++) begin
				acc_wdata[(3-k)*SUM_W-1 -: SUM_W] =
					acc_sel[(3-k)*SUM_W-1 -: SUM_W] + SUM_W'(n_q[k]);
			end
		end
	end

	// Position memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[corner[0]] <= wpos_q;
		end
		pos_rd_q <= pos_mem[corner_sel];
	end

	// Accumulator memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[corner_sel];
	end

	// Edge vectors, cross product terms and the count-full check
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			du[k] = (POS_W+1)'($signed(pos_c_q[1][(3-k)*POS_W-1 -: POS_W]))
				- (POS_W+1)'($signed(pos_c_q[0][(3-k)*POS_W-1 -: POS_W]));
			dw[k] = (POS_W+1)'($signed(pos_c_q[2][(3-k)*POS_W-1 -: POS_W]))
				- (POS_W+1)'($signed(pos_c_q[0][(3-k)*POS_W-1 -: POS_W]));
		end
		prod_d[0] = du[1] * dw[2];
		prod_d[1] = du[2] * dw[1];
		prod_d[2] = du[2] * dw[0];
		prod_d[3] = du[0] * dw[2];
		prod_d[4] = du[0] * dw[1];
		prod_d[5] = du[1] * dw[0];
		full_d = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if ((CW+2)'(acc_c_q[k][ACC_W-1 -: CW]) + (CW+2)'(occ[k]) > MAX_LIM) begin
				full_d = 1'b1;
			end
		end
	end

	// Divider lane step: shift in one dividend bit, subtract when it fits
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rem_sh[k] = {rem_q[k], quo_q[k][SUM_W-1]};
			ge[k]     = (rem_sh[k] >= {1'b0, divisor_q});
			qs[k]     = neg_q[k] ? (SUM_W'(0) - quo_q[k]) : quo_q[k];
		end
	end

	// Next state and result selection
	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		out_status = STAT_OK;
		out_total  = '0;
		for (int k = 0; k < 3; k++) begin
			out_n[k] = '0;
		end
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = (RED_STEPS > 0) ? ST_REDUCE : ST_EXEC;
				end
			end
			ST_REDUCE: begin
				if (dsh_q == DEPTH_LOW) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (req_q)
					REQ_FACE: state_d = ST_FETCH;
					REQ_READ: state_d = ST_RDWAIT;
					default: begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_FETCH: begin
				if (cnt_q == 2'd3) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_NORM;
			ST_NORM: begin
				if (full_q) begin
					emit       = 1'b1;
					out_status = STAT_FULL;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				if (cnt_q == 2'd2) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					for (int k = 0; k < 3; k++) begin
						out_n[k] = n_q[k];
					end
				end
			end
			ST_RDWAIT: begin
				if (rd_count == '0) begin
					emit       = 1'b1;
					out_status = STAT_NO_FACES;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (dcnt_q == DIV_LAST) begin
					state_d = ST_RDDONE;
				end
			end
			ST_RDDONE: begin
				emit      = 1'b1;
				state_d   = ST_IDLE;
				out_total = TOTAL_W'(divisor_q);
				for (int k = 0; k < 3; k++) begin
					out_n[k] = qs[k][NORM_W-1:0];
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// Park the slot counter at zero while idle so the first read hits corner a
			if (state_q == ST_EXEC) begin
				cnt_q <= 2'd1;
			end else if (state_q == ST_FETCH || state_q == ST_WB) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_MUL || state_q == ST_IDLE) begin
				cnt_q <= '0;
			end
			if (state_q == ST_RDWAIT) begin
				dcnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Capture request
		if (state_q == ST_IDLE && start) begin
			req_q    <= req_type;
			raw_q[0] <= vertex_a;
			raw_q[1] <= vertex_b;
			raw_q[2] <= vertex_c;
			wpos_q   <= {pos_x, pos_y, pos_z};
			dsh_q    <= RED_TOP;
		end
		// Reduce indices modulo the depth, one shifted subtract per cycle
		if (state_q == ST_REDUCE) begin
			for (int k = 0; k < 3; k++) begin
				if (raw_q[k] >= dsh_q) begin
					raw_q[k] <= raw_q[k] - dsh_q;
				end
			end
			dsh_q <= dsh_q >> 1;
		end
		// Collect corner positions and accumulator words
		if (state_q == ST_FETCH) begin
			for (int k = 0; k < 3; k++) begin
				if (cnt_q == 2'(k + 1)) begin
					pos_c_q[k] <= pos_rd_q;
					acc_c_q[k] <= acc_rd_q;
				end
			end
		end
		if (state_q == ST_MUL) begin
			for (int k = 0; k < 6; k++) begin
				prod_q[k] <= prod_d[k];
			end
			full_q <= full_d;
		end
		// Negated cross product: each component is the second term minus the first
		if (state_q == ST_NORM) begin
			for (int k = 0; k < 3; k++) begin
				n_q[k] <= NORM_W'(prod_q[2*k+1] - prod_q[2*k]);
			end
		end
		// Load divider with sum magnitudes
		if (state_q == ST_RDWAIT) begin
			divisor_q <= rd_count;
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= acc_rd_q[(3-k)*SUM_W-1];
				quo_q[k] <= acc_rd_q[(3-k)*SUM_W-1]
					? (SUM_W'(0) - acc_rd_q[(3-k)*SUM_W-1 -: SUM_W])
					: acc_rd_q[(3-k)*SUM_W-1 -: SUM_W];
				rem_q[k] <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= ge[k] ? CW'(rem_sh[k] - {1'b0, divisor_q}) : CW'(rem_sh[k]);
				quo_q[k] <= {quo_q[k][SUM_W-2:0], ge[k]};
			end
		end
		// Hold result
		if (emit) begin
			status_q <= out_status;
			total_q  <= out_total;
			for (int k = 0; k < 3; k++) begin
				nrm_q[k] <= out_n[k];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/mvna_checker.sv
`default_nettype none

module mvna_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic                                done,
	input wire logic [mvna_pkg::STAT_W-1:0]         status,
	input wire logic signed [mvna_pkg::NORM_W-1:0]  norm_x,
	input wire logic signed [mvna_pkg::NORM_W-1:0]  norm_y,
	input wire logic signed [mvna_pkg::NORM_W-1:0]  norm_z,
	input wire logic [mvna_pkg::TOTAL_W-1:0]        face_total
);
	import mvna_pkg::*;

	// An accepted request keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but busy not raised");

	// A result only shows once the block is ready for the next request
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// One result per request: results never come in adjacent cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in adjacent cycles");

	// Any non-ok status carries a zero normal and no face total
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |->
			(norm_x == '0) && (norm_y == '0) && (norm_z == '0) && (face_total == '0))
		else $error("error status with nonzero payload");

endmodule

bind mesh_vertex_normal_accumulator_unit mvna_checker u_mvna_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.norm_x     (norm_x),
	.norm_y     (norm_y),
	.norm_z     (norm_z),
	.face_total (face_total)
);

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mvna_pkg::*;

	localparam int VDEPTH      = DEF_VERTEX_DEPTH;
	localparam int FACE_LIMIT  = DEF_MAX_FACES;
	localparam int TOTAL_ITEMS = 450;
	localparam int RECENT      = 12;
	localparam int DRAIN_WAIT  = 60;

	// Request code the block does not define
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	// How a stimulus row is checked
	localparam logic CHK_MODEL = 1'b0;
	localparam logic CHK_TYPED = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]        op;
		logic [IDX_IN_W-1:0]     a;
		logic [IDX_IN_W-1:0]     b;
		logic [IDX_IN_W-1:0]     c;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic                    chk;
		logic [STAT_W-1:0]       st;
	} stim_row_t;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic [TOTAL_W-1:0]       total;
	} normal_t;

	// Directed requests: empty reads, extremes, largest normal, repeated corner,
	// clear on rewrite, unknown code
	localparam int N_DIRECTED = 25;
	localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
		'{REQ_READ,    10'd0,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_NO_FACES},
		'{REQ_READ,    10'd1023, 10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_NO_FACES},
		'{REQ_UNKNOWN, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd0,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd1,    10'd0,    10'd0,    16'h7FFF, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd2,    10'd0,    10'd0,    16'h0000, 16'h7FFF, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd1023, 10'd0,    10'd0,    16'h8000, 16'h8000, 16'h8000,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd512,  10'd0,    10'd0,    16'h7FFF, 16'h7FFF, 16'h7FFF,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd3,    10'd0,    10'd0,    16'h8000, 16'h7FFF, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd4,    10'd0,    10'd0,    16'h7FFF, 16'h8000, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_WRITE,   10'd5,    10'd0,    10'd0,    16'h7FFF, 16'h7FFF, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_FACE,    10'd0,    10'd1,    10'd2,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_FACE,    10'd3,    10'd4,    10'd5,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_FACE,    10'd1023, 10'd512,  10'd1,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_FACE,    10'd2,    10'd2,    10'd1,    16'h0000, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_FACE,    10'd1023, 10'd1,    10'd2,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_READ,    10'd2,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_READ,    10'd1023, 10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_READ,    10'd3,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_WRITE,   10'd2,    10'd0,    10'd0,    16'hFFFF, 16'hFFFF, 16'hFFFF,
			CHK_TYPED, STAT_OK},
		'{REQ_READ,    10'd2,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_NO_FACES},
		'{REQ_FACE,    10'd512,  10'd1023, 10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_READ,    10'd0,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_MODEL, STAT_OK},
		'{REQ_UNKNOWN, 10'd0,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_OK},
		'{REQ_READ,    10'd6,    10'd0,    10'd0,    16'h0000, 16'h0000, 16'h0000,
			CHK_TYPED, STAT_NO_FACES}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [REQ_W-1:0]         req_type;
	logic [IDX_IN_W-1:0]      vertex_a;
	logic [IDX_IN_W-1:0]      vertex_b;
	logic [IDX_IN_W-1:0]      vertex_c;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic                     done;
	logic [STAT_W-1:0]        status;
	logic signed [NORM_W-1:0] norm_x;
	logic signed [NORM_W-1:0] norm_y;
	logic signed [NORM_W-1:0] norm_z;
	logic [TOTAL_W-1:0]       face_total;

	// Mesh mirror: positions, normal sums and face counts
	logic signed [POS_W-1:0] vtx_pos_x [VDEPTH];
	logic signed [POS_W-1:0] vtx_pos_y [VDEPTH];
	logic signed [POS_W-1:0] vtx_pos_z [VDEPTH];
	longint                  vtx_sum_x [VDEPTH];
	longint                  vtx_sum_y [VDEPTH];
	longint                  vtx_sum_z [VDEPTH];
	int                      vtx_count [VDEPTH];
	int                      placed_vtx [$];

	normal_t pending_normals [$];

	int  mismatches   = 0;
	int  items_sent   = 0;
	int  normals_seen = 0;
	int  n_writes     = 0;
	int  n_faces_ok   = 0;
	int  n_faces_full = 0;
	int  n_reads_avg  = 0;
	int  n_reads_none = 0;
	int  n_unknown    = 0;
	bit  steady       = 1'b0;

	mesh_vertex_normal_accumulator_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.vertex_a   (vertex_a),
		.vertex_b   (vertex_b),
		.vertex_c   (vertex_c),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.done       (done),
		.status     (status),
		.norm_x     (norm_x),
		.norm_y     (norm_y),
		.norm_z     (norm_z),
		.face_total (face_total)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Keep a sum inside its 43-bit signed range
	function automatic longint wrap_sum(input longint v);
		logic signed [SUM_W-1:0] t;
		t = v[SUM_W-1:0];
		return longint'(t);
	endfunction

	// Bias coordinates toward the extremes
	function automatic logic signed [POS_W-1:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return POS_W'($urandom);
		endcase
	endfunction

	// Pick one of the recently written vertices
	function automatic int pick_live();
		int span;
		span = (placed_vtx.size() < RECENT) ? placed_vtx.size() : RECENT;
		return placed_vtx[placed_vtx.size() - 1 - $urandom_range(span - 1)];
	endfunction

	function automatic int pick_other(input int hub);
		int v;
		v = pick_live();
		while (v == hub)
			v = pick_live();
		return v;
	endfunction

	// Update the mesh mirror and work out the result of one request
	task automatic apply_to_mesh(input stim_row_t rq, output normal_t res);
		int     a, b, c;
		int     corner [3];
		int     occ;
		bit     full;
		longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
		a = int'(rq.a) % VDEPTH;
		b = int'(rq.b) % VDEPTH;
		c = int'(rq.c) % VDEPTH;
		res.status = STAT_OK;
		res.nx = '0;
		res.ny = '0;
		res.nz = '0;
		res.total = '0;
		case (rq.op)
			REQ_WRITE: begin
				vtx_pos_x[a] = rq.x;
				vtx_pos_y[a] = rq.y;
				vtx_pos_z[a] = rq.z;
				vtx_sum_x[a] = 0;
				vtx_sum_y[a] = 0;
				vtx_sum_z[a] = 0;
				vtx_count[a] = 0;
				placed_vtx.insert(placed_vtx.size(), a);
				n_writes++;
			end
			REQ_FACE: begin
				corner[0] = a;
				corner[1] = b;
				corner[2] = c;
				full = 1'b0;
				// Reject the whole face if any corner would pass the count limit
				for (int i = 0; i < 3; i++) begin
					occ = 0;
					for (int j = 0; j < 3; j++)
						if (corner[j] == corner[i])
							occ++;
					if (vtx_count[corner[i]] + occ > FACE_LIMIT)
						full = 1'b1;
				end
				if (full) begin
					res.status = STAT_FULL;
					n_faces_full++;
				end else begin
					ux = longint'(vtx_pos_x[b]) - longint'(vtx_pos_x[a]);
					uy = longint'(vtx_pos_y[b]) - longint'(vtx_pos_y[a]);
					uz = longint'(vtx_pos_z[b]) - longint'(vtx_pos_z[a]);
					wx = longint'(vtx_pos_x[c]) - longint'(vtx_pos_x[a]);
					wy = longint'(vtx_pos_y[c]) - longint'(vtx_pos_y[a]);
					wz = longint'(vtx_pos_z[c]) - longint'(vtx_pos_z[a]);
					nx = -(uy * wz - uz * wy);
					ny = -(uz * wx - ux * wz);
					nz = -(ux * wy - uy * wx);
					res.nx = nx[NORM_W-1:0];
					res.ny = ny[NORM_W-1:0];
					res.nz = nz[NORM_W-1:0];
					for (int i = 0; i < 3; i++) begin
						vtx_sum_x[corner[i]] = wrap_sum(vtx_sum_x[corner[i]] + nx);
						vtx_sum_y[corner[i]] = wrap_sum(vtx_sum_y[corner[i]] + ny);
						vtx_sum_z[corner[i]] = wrap_sum(vtx_sum_z[corner[i]] + nz);
						vtx_count[corner[i]]++;
					end
					n_faces_ok++;
				end
			end
			REQ_READ: begin
				if (vtx_count[a] == 0) begin
					res.status = STAT_NO_FACES;
					n_reads_none++;
				end else begin
					// Signed division truncates toward zero
					nx = vtx_sum_x[a] / longint'(vtx_count[a]);
					ny = vtx_sum_y[a] / longint'(vtx_count[a]);
					nz = vtx_sum_z[a] / longint'(vtx_count[a]);
					res.nx = nx[NORM_W-1:0];
					res.ny = ny[NORM_W-1:0];
					res.nz = nz[NORM_W-1:0];
					res.total = vtx_count[a][TOTAL_W-1:0];
					n_reads_avg++;
				end
			end
			default: begin
				n_unknown++;
			end
		endcase
	endtask

	// Offer one request, hold it until taken, then queue its expected normal.
	// Enter and leave on a falling edge.
	task automatic send_request(input stim_row_t rq);
		normal_t res;
		bit      taken;
		// Idle at random, with noise on the fields
		if (!steady) begin
			while ($urandom_range(99) < 34) begin
				start    <= 1'b0;
				req_type <= REQ_W'($urandom);
				vertex_a <= IDX_IN_W'($urandom);
				vertex_b <= IDX_IN_W'($urandom);
				vertex_c <= IDX_IN_W'($urandom);
				pos_x    <= POS_W'($urandom);
				pos_y    <= POS_W'($urandom);
				pos_z    <= POS_W'($urandom);
				@(negedge clk);
			end
		end
		start    <= 1'b1;
		req_type <= rq.op;
		vertex_a <= rq.a;
		vertex_b <= rq.b;
		vertex_c <= rq.c;
		pos_x    <= rq.x;
		pos_y    <= rq.y;
		pos_z    <= rq.z;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		apply_to_mesh(rq, res);
		if (rq.chk == CHK_TYPED) begin
			res.status = rq.st;
			res.nx = '0;
			res.ny = '0;
			res.nz = '0;
			res.total = '0;
		end
		pending_normals.insert(pending_normals.size(), res);
		items_sent++;
		@(negedge clk);
	endtask

	// Drive a vertex up to its face limit, probe the boundary, then clear it
	task automatic saturate_vertex(input int hub);
		stim_row_t rq;
		rq = '0;
		rq.op = REQ_FACE;
		rq.chk = CHK_MODEL;
		rq.a = IDX_IN_W'(hub);
		rq.b = IDX_IN_W'(hub);
		rq.c = IDX_IN_W'(hub);
		while (vtx_count[hub] <= FACE_LIMIT - 3)
			send_request(rq);
		repeat (8) begin
			rq.b = IDX_IN_W'(pick_other(hub));
			rq.c = IDX_IN_W'(pick_other(hub));
			case ($urandom_range(2))
				0: begin
					rq.b = IDX_IN_W'(hub);
					rq.c = IDX_IN_W'(hub);
				end
				1: begin
					rq.b = IDX_IN_W'(hub);
				end
				default: begin
				end
			endcase
			send_request(rq);
		end
		rq.op = REQ_READ;
		send_request(rq);
		rq.op = REQ_WRITE;
		rq.x = rand_coord();
		rq.y = rand_coord();
		rq.z = rand_coord();
		send_request(rq);
		rq.op = REQ_READ;
		send_request(rq);
	endtask

	// Compare one result field
	task automatic check_field(input string fname, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// Match each returned normal against the oldest pending one
	always @(posedge clk) begin : check_results
		normal_t want;
		if (done === 1'b1) begin
			normals_seen++;
			if (pending_normals.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got status %0d", $time,
					status);
				mismatches++;
			end else begin
				want = pending_normals.pop_front();
				check_field("status", want.status, status);
				check_field("norm_x", want.nx, norm_x);
				check_field("norm_y", want.ny, norm_y);
				check_field("norm_z", want.nz, norm_z);
				check_field("face_total", want.total, face_total);
			end
		end
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		stim_row_t rq;
		bit        paused;
		bit        sat_early;
		bit        sat_late;
		int        pick;
		arst_n   = 1'b0;
		start    = 1'b0;
		req_type = '0;
		vertex_a = '0;
		vertex_b = '0;
		vertex_c = '0;
		pos_x    = '0;
		pos_y    = '0;
		pos_z    = '0;
		paused    = 1'b0;
		sat_early = 1'b0;
		sat_late  = 1'b0;
		for (int i = 0; i < VDEPTH; i++) begin
			vtx_pos_x[i] = '0;
			vtx_pos_y[i] = '0;
			vtx_pos_z[i] = '0;
			vtx_sum_x[i] = 0;
			vtx_sum_y[i] = 0;
			vtx_sum_z[i] = 0;
			vtx_count[i] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (int i = 0; i < N_DIRECTED; i++)
			send_request(DIRECTED_ROWS[i]);

		// Random traffic, mostly well-formed on written vertices
		while (items_sent < TOTAL_ITEMS) begin
			if (!sat_early && items_sent >= 100) begin
				sat_early = 1'b1;
				saturate_vertex(pick_live());
			end else if (!paused && items_sent >= 220) begin
				// Hold off until every pending normal has come back
				paused = 1'b1;
				start <= 1'b0;
				@(negedge clk);
				while (pending_normals.size() != 0)
					@(negedge clk);
			end else if (!sat_late && items_sent >= 280) begin
				sat_late = 1'b1;
				saturate_vertex(pick_live());
			end else begin
				steady = (items_sent >= 330 && items_sent < 420);
				rq = '0;
				rq.chk = CHK_MODEL;
				rq.a = IDX_IN_W'($urandom);
				rq.b = IDX_IN_W'($urandom);
				rq.c = IDX_IN_W'($urandom);
				rq.x = rand_coord();
				rq.y = rand_coord();
				rq.z = rand_coord();
				pick = $urandom_range(99);
				if (pick < 22) begin
					rq.op = REQ_WRITE;
				end else if (pick < 62) begin
					rq.op = REQ_FACE;
					rq.a = IDX_IN_W'(pick_live());
					rq.b = IDX_IN_W'(pick_live());
					rq.c = ($urandom_range(9) == 0) ? rq.a : IDX_IN_W'(pick_live());
				end else if (pick < 90) begin
					rq.op = REQ_READ;
					if ($urandom_range(4) != 0)
						rq.a = IDX_IN_W'(pick_live());
				end else begin
					rq.op = REQ_UNKNOWN;
				end
				send_request(rq);
			end
		end
		steady = 1'b0;

		// Drain, then allow for the slowest request
		start <= 1'b0;
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d requests: %0d writes, %0d faces added, %0d faces rejected full,",
			items_sent, n_writes, n_faces_ok, n_faces_full);
		$display("%0d averaged reads, %0d reads of faceless vertices, %0d unknown codes.",
			n_reads_avg, n_reads_none, n_unknown);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
